// ===== sv/serial_frame_deframer_top_defines.svh =====
// assertion macros for the serial frame deframer
// used by serial_frame_deframer_top.sv, needs signals clock and reset in scope
`ifndef SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH

// plain property, checked on every clock edge outside reset
`define SFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define SFD_IMPLY(label, ante, cons, msg) \
   `SFD_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/sfd_pkg.sv =====
// types, constants and codes shared by the serial frame deframer
// no dependencies
`default_nettype none

package sfd_pkg;

   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 6;
   localparam int STATUS_W        = 2;
   localparam int CSR_IDX_W       = 8;
   localparam int MAX_PAYLOAD_DEF = 40;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_ID    = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_SUM   = 3'd5
   } phase_type;

   typedef enum logic {
      B_IDLE = 1'b0,
      B_EMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
   } hdr_cfg_type;

   // one finished frame, handed from parser to emitter
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   msg_id;
      logic [LEN_W-1:0]    frame_length;
      logic                bank;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [LEN_W-1:0]  pos;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

endpackage

`default_nettype wire

// ===== sv/sfd_channels.sv =====
// valid/ready channel interfaces of the serial frame deframer
// depends on sfd_pkg
`default_nettype none

interface sfd_req_if import sfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if import sfd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   msg_id;
   logic [LEN_W-1:0]    frame_length;
   logic [LEN_W-1:0]    byte_index;
   logic [BYTE_W-1:0]   payload_byte;
   logic                last;

   modport source (output valid, output status, output msg_id, output frame_length,
                   output byte_index, output payload_byte, output last, input ready);
   modport sink   (input valid, input status, input msg_id, input frame_length,
                   input byte_index, input payload_byte, input last, output ready);
endinterface

interface sfd_csr_if import sfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/sfd_front.sv =====
// frame parser: hunts headers, keeps the running sum, stores payload bytes
// depends on sfd_pkg and sfd_channels
`default_nettype none

module sfd_front
   import sfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire hdr_cfg_type cfg,
   sfd_req_if.sink          req_bus,
   output logic             push,
   output desc_type         push_desc,
   input  wire logic        q_full,
   output mem_wr_type       mem_wr,
   input  wire release_type release_in
);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] held_id_ff, held_id_in;
   logic [LEN_W-1:0]  held_length_ff, held_length_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  wpos_ff, wpos_in;
   logic              wbank_ff, wbank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              accept;
   logic [BYTE_W-1:0] rx;
   logic [BYTE_W-1:0] sum_next;
   logic [LEN_W-1:0]  remaining_dec;
   logic              len_bad;
   logic [STATUS_W-1:0] frame_status;

   assign rx            = req_bus.rx_byte;
   assign sum_next      = sum_ff + rx;
   assign remaining_dec = remaining_ff - LEN_W'(1);
   assign len_bad       = rx > BYTE_W'(MAX_PAYLOAD);

   // stall on a full queue at the checksum, or on a bank still being read out
   assign req_bus.ready = !((phase_ff == PH_SUM) && q_full)
                       && !((phase_ff == PH_DATA) && busy_ff[wbank_ff]);
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      if (rx != sum_ff) begin
         frame_status = ST_MISMATCH;
      end else if (held_length_ff == '0) begin
         frame_status = ST_EMPTY;
      end else begin
         frame_status = ST_PAYLOAD;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx == cfg.header_first) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               phase_in = (rx == cfg.header_second) ? PH_ID : PH_HUNT1;
            end
            PH_ID: begin
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (len_bad) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = (rx == '0) ? PH_SUM : PH_DATA;
               end
            end
            PH_DATA: begin
               if (remaining_dec == '0) phase_in = PH_SUM;
            end
            PH_SUM: begin
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      held_id_in     = held_id_ff;
      held_length_in = held_length_ff;
      remaining_in   = remaining_ff;
      sum_in         = sum_ff;
      wpos_in        = wpos_ff;
      wbank_in       = wbank_ff;
      busy_in        = busy_ff;
      push           = 1'b0;
      push_desc.status       = frame_status;
      push_desc.msg_id       = held_id_ff;
      push_desc.frame_length = held_length_ff;
      push_desc.bank         = wbank_ff;
      mem_wr.en   = 1'b0;
      mem_wr.bank = wbank_ff;
      mem_wr.pos  = wpos_ff;
      mem_wr.data = rx;

      if (release_in.en) busy_in[release_in.bank] = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx == cfg.header_first) sum_in = rx;
            end
            PH_HUNT2: begin
               if (rx == cfg.header_second) begin
                  sum_in = sum_next;
               end else begin
                  sum_in       = '0;
                  wpos_in      = '0;
                  remaining_in = '0;
               end
            end
            PH_ID: begin
               held_id_in = rx;
               sum_in     = sum_next;
            end
            PH_LEN: begin
               wpos_in      = '0;
               remaining_in = '0;
               if (len_bad) begin
                  sum_in = '0;
               end else begin
                  held_length_in = rx[LEN_W-1:0];
                  remaining_in   = rx[LEN_W-1:0];
                  sum_in         = sum_next;
               end
            end
            PH_DATA: begin
               mem_wr.en    = 1'b1;
               wpos_in      = wpos_ff + LEN_W'(1);
               sum_in       = sum_next;
               remaining_in = remaining_dec;
            end
            PH_SUM: begin
               push         = 1'b1;
               sum_in       = '0;
               wpos_in      = '0;
               remaining_in = '0;
               // a payload frame holds its bank until read out
               if (frame_status == ST_PAYLOAD) begin
                  busy_in[wbank_ff] = 1'b1;
                  wbank_in          = !wbank_ff;
               end
            end
            default: begin
               sum_in       = '0;
               wpos_in      = '0;
               remaining_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT1;
         held_id_ff     <= '0;
         held_length_ff <= '0;
         remaining_ff   <= '0;
         sum_ff         <= '0;
         wpos_ff        <= '0;
         wbank_ff       <= 1'b0;
         busy_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_id_ff     <= held_id_in;
         held_length_ff <= held_length_in;
         remaining_ff   <= remaining_in;
         sum_ff         <= sum_in;
         wpos_ff        <= wpos_in;
         wbank_ff       <= wbank_in;
         busy_ff        <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sfd_queue.sv =====
// short frame queue between parser and emitter
// depends on sfd_pkg
`default_nettype none

module sfd_queue
   import sfd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output desc_type      head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   desc_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = count_ff == CW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

`default_nettype wire

// ===== sv/sfd_back.sv =====
// result emitter: owns the two-bank payload memory and plays frames out
// depends on sfd_pkg and sfd_channels
`default_nettype none

module sfd_back
   import sfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire desc_type   head,
   output logic            pop,
   input  wire mem_wr_type mem_wr,
   output release_type     release_out,
   sfd_rsp_if.source       rsp_bus
);

   localparam int IW        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int AW        = IW + 1;
   localparam int MEM_DEPTH = 2 ** AW;

   logic [BYTE_W-1:0] mem [MEM_DEPTH];

   back_state_type    state_ff, state_in;
   desc_type          cur_ff, cur_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;

   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0]   id_ff, id_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    bidx_ff, bidx_in;
   logic                last_ff, last_in;
   logic [BYTE_W-1:0]   rd_data_ff;

   logic              advance;
   logic              load;
   logic              issue;
   logic              is_last;
   logic              rd_bank;
   logic [LEN_W-1:0]  rd_idx;
   logic [AW-1:0]     rd_addr;

   // the output register frees up when empty or taken this cycle
   assign advance = !valid_ff || rsp_bus.ready;
   assign rd_addr = {rd_bank, rd_idx[IW-1:0]};

   // outputs per state
   always_comb begin
      pop       = 1'b0;
      load      = 1'b0;
      issue     = 1'b0;
      is_last   = 1'b0;
      rd_bank   = cur_ff.bank;
      rd_idx    = idx_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      bidx_in   = bidx_ff;
      last_in   = last_ff;
      release_out.en   = 1'b0;
      release_out.bank = cur_ff.bank;

      unique case (state_ff)
         B_IDLE: begin
            if (advance && head_valid) begin
               pop       = 1'b1;
               load      = 1'b1;
               status_in = head.status;
               id_in     = head.msg_id;
               len_in    = head.frame_length;
               bidx_in   = '0;
               if (head.status == ST_PAYLOAD) begin
                  issue    = 1'b1;
                  rd_bank  = head.bank;
                  rd_idx   = '0;
                  is_last  = head.frame_length == LEN_W'(1);
                  cur_in   = head;
                  idx_in   = LEN_W'(1);
                  release_out.en   = is_last;
                  release_out.bank = head.bank;
               end else begin
                  is_last = 1'b1;
               end
               last_in = is_last;
            end
         end
         B_EMIT: begin
            if (advance) begin
               load      = 1'b1;
               issue     = 1'b1;
               is_last   = idx_ff == (cur_ff.frame_length - LEN_W'(1));
               status_in = ST_PAYLOAD;
               id_in     = cur_ff.msg_id;
               len_in    = cur_ff.frame_length;
               bidx_in   = idx_ff;
               last_in   = is_last;
               idx_in    = idx_ff + LEN_W'(1);
               release_out.en = is_last;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop && (head.status == ST_PAYLOAD) && !is_last) state_in = B_EMIT;
         end
         B_EMIT: begin
            if (advance && is_last) state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      len_ff    <= len_in;
      bidx_ff   <= bidx_in;
      last_ff   <= last_in;
   end

   // payload memory, read data register doubles as the output byte
   always_ff @(posedge clock) begin
      if (mem_wr.en) mem[{mem_wr.bank, mem_wr.pos[IW-1:0]}] <= mem_wr.data;
      if (issue) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.msg_id       = id_ff;
   assign rsp_bus.frame_length = len_ff;
   assign rsp_bus.byte_index   = bidx_ff;
   assign rsp_bus.payload_byte = (status_ff == ST_PAYLOAD) ? rd_data_ff : '0;
   assign rsp_bus.last         = last_ff;

endmodule

`default_nettype wire

// ===== sv/serial_frame_deframer_top.sv =====
// top level of the serial frame deframer: header registers, parser, queue, emitter
// depends on sfd_pkg, sfd_channels, sfd_front, sfd_queue, sfd_back and the defines header
`default_nettype none
`include "serial_frame_deframer_top_defines.svh"

// Parses a received byte stream into frames (two header bytes, id, length up to
// MAX_PAYLOAD, payload, 8-bit additive checksum) and delivers one item per payload
// byte of a good frame, one item for a good empty frame, or one mismatch item.
// The parser takes one byte per clock; it holds req ready low only at a checksum
// byte while the two-entry frame queue is full, or on a payload byte while both
// payload banks still hold frames not yet played out. The emitter delivers one
// item per clock while rsp ready is high; once a frame's checksum byte is taken,
// it passes through the queue and then the registered payload memory read before
// its first item appears. Header registers are written through the csr channel,
// which is always ready; the payload memory needs no clearing after reset.
module serial_frame_deframer_top
   import sfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sfd_req_if.sink   req_bus,
   sfd_rsp_if.source rsp_bus,
   sfd_csr_if.sink   csr_bus
);

   hdr_cfg_type cfg_ff, cfg_in;

   logic        push;
   desc_type    push_desc;
   logic        q_full;
   logic        pop;
   logic        head_valid;
   desc_type    head;
   mem_wr_type  mem_wr;
   release_type release_bus;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_HEADER_FIRST:  cfg_in.header_first  = csr_bus.wdata;
            REG_HEADER_SECOND: cfg_in.header_second = csr_bus.wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RST;
         cfg_ff.header_second <= HEADER_SECOND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .push       (push),
      .push_desc  (push_desc),
      .q_full     (q_full),
      .mem_wr     (mem_wr),
      .release_in (release_bus)
   );

   sfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   sfd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .mem_wr      (mem_wr),
      .release_out (release_bus),
      .rsp_bus     (rsp_bus)
   );

   // parser never pushes into a full queue
   `SFD_IMPLY(a_push_not_full, push, !q_full, "frame pushed into full queue")
   // emitter only pops a waiting frame
   `SFD_IMPLY(a_pop_has_head, pop, head_valid, "frame popped from empty queue")
   // a bank is never written while its last byte is being read out
   `SFD_ASSERT(a_bank_no_clash, !(mem_wr.en && release_bus.en && (mem_wr.bank == release_bus.bank)), "payload bank written while being read out")
   // a bank is only released while the output register has space
   `SFD_IMPLY(a_release_payload, release_bus.en, rsp_bus.ready || !rsp_bus.valid, "bank released without output space")

endmodule

`default_nettype wire
